// ----- rtl/fixed_partition_fit_allocator_core_macros.svh -----
// assertion macros for the fixed partition fit allocator
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FPFA_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fpfa: same-cycle check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpfa: next-cycle check failed");

`endif

// ----- rtl/fpfa_pkg.sv -----
// shared types and constants of the fixed partition fit allocator
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int MAX_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    // external field widths
    localparam int IDX_FIELD_W  = 5;
    localparam int SIZE_FIELD_W = 16;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    // placement rules, the unused code behaves as first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [1:0] STAT_LOADED = 2'd0;
    localparam logic [1:0] STAT_ALLOC  = 2'd1;
    localparam logic [1:0] STAT_NOFIT  = 2'd2;

    localparam logic [5:0] BLOCK_COUNT_RST = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // verdict of the fit unit on one block entry
    typedef struct packed {
        logic fits;
        logic take;
    } t_fit_flags;

endpackage

// ----- rtl/fpfa_store.sv -----
// block size memory and used flags of the allocator
`timescale 1ns / 1ps

module fpfa_store #(
    parameter int MAX_BLOCKS = fpfa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  logic [SIZE_BITS-1:0] i_wr_size,
    input  logic                 i_set_en,
    input  logic [IDX_W-1:0]     i_set_addr,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output logic [SIZE_BITS-1:0] o_rd_size,
    output logic                 o_rd_used
);

    logic [SIZE_BITS-1:0]  r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_used;
    logic [SIZE_BITS-1:0]  r_rd_size;
    logic                  r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_size;
        end
        r_rd_size <= r_mem[i_rd_addr];
    end

    // load frees an entry, an allocation marks it used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_used[i_wr_addr] <= 1'b0;
            end
            if (i_set_en) begin
                r_used[i_set_addr] <= 1'b1;
            end
            r_rd_used <= r_used[i_rd_addr];
        end
    end

    assign o_rd_size = r_rd_size;
    assign o_rd_used = r_rd_used;

endmodule

// ----- rtl/fpfa_fit_unit.sv -----
// shared subtract and compare unit that judges one block entry
`timescale 1ns / 1ps

module fpfa_fit_unit #(
    parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
    input  logic [1:0]           i_policy,
    input  logic                 i_found,
    input  logic [SIZE_BITS-1:0] i_best,
    input  logic [SIZE_BITS-1:0] i_size,
    input  logic                 i_used,
    input  logic [SIZE_BITS-1:0] i_req,
    output logic [SIZE_BITS-1:0] o_rest,
    output fpfa_pkg::t_fit_flags o_flags
);

    logic w_fits;
    logic w_better;

    always_comb begin
        o_rest   = i_size - i_req;
        w_fits   = !i_used && (i_size >= i_req);
        // strict compares keep ties on the lowest index
        w_better = !i_found
                || ((i_policy == fpfa_pkg::POL_BEST)  && (o_rest < i_best))
                || ((i_policy == fpfa_pkg::POL_WORST) && (o_rest > i_best));
        o_flags.fits = w_fits;
        o_flags.take = w_fits && w_better;
    end

endmodule

// ----- rtl/fixed_partition_fit_allocator_core.sv -----
// top level of the fixed partition fit allocator
`timescale 1ns / 1ps
`include "fixed_partition_fit_allocator_core_macros.svh"

// Fixed-partition allocator with first, best or worst fit. A load beat
// (tuser command 0) writes a block size and frees that block; its result
// beat has status 0. An allocate beat (command 1) scans the free blocks
// below block_count, one entry per cycle through the single read port of
// the size memory and one shared subtract/compare unit, marks the chosen
// block used and returns its index and the leftover (status 1), or status
// 2 when nothing fits. Ties go to the lowest index; first fit stops at the
// first hit. Sequence: a load beat goes straight to the result register;
// an allocate beat reads each entry below limit (limit =
// min(block_count, MAX_BLOCKS)), judges each entry as its read returns,
// closes the scan once the last read is judged, then fills the result
// register. First fit hitting early ends the scan sooner; a stalled
// result register holds the core until it drains. Only one beat is in
// flight; the input is ready again once the result is in the output
// register, even while that result waits. Used flags reset to free;
// no clearing pass. Block sizes are undefined until loaded.
// Configuration is not gated here: write it only while idle, since
// the policy is read live during a scan.
module fixed_partition_fit_allocator_core #(
    parameter int MAX_BLOCKS = fpfa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // block_index[4:0], size_value[20:5], zero pad
    input  logic [0:0]  s_axis_tuser,   // command[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // chosen_block[4:0], leftover[20:5], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // configuration
    logic [1:0] r_policy;
    logic [5:0] r_count;

    // sequencer and scan state
    fpfa_pkg::t_state     r_state, n_state;
    logic                 r_cmd, n_cmd;
    logic [SIZE_BITS-1:0] r_req, n_req;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic [CNT_W-1:0]     r_limit, n_limit;
    logic                 r_ev_valid, n_ev_valid;
    logic [IDX_W-1:0]     r_ev_idx, n_ev_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_best, n_best;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_status, n_out_status;
    logic [4:0]  r_out_block, n_out_block;
    logic [15:0] r_out_left, n_out_left;

    logic                 w_s_acc;
    logic                 w_in_cmd;
    logic [4:0]           w_in_idx;
    logic [15:0]          w_in_size;
    logic                 w_load_wr;
    logic                 w_first;
    logic                 w_issue;
    logic                 w_out_free;
    logic                 w_fin_go;
    logic [SIZE_BITS-1:0] w_rd_size;
    logic                 w_rd_used;
    logic [SIZE_BITS-1:0] w_rest;
    fpfa_pkg::t_fit_flags w_flags;

    // unpack the request beat
    assign w_in_cmd  = s_axis_tuser[0];
    assign w_in_idx  = s_axis_tdata[4:0];
    assign w_in_size = s_axis_tdata[20:5];

    assign s_axis_tready = (r_state == fpfa_pkg::ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    // load writes the memory at accept; out-of-range index writes nothing
    assign w_load_wr = w_s_acc && (w_in_cmd == fpfa_pkg::CMD_LOAD)
                     && ({27'd0, w_in_idx} < MAX_BLOCKS);

    // unused policy code acts as first fit: stop issuing after a hit
    assign w_first = (r_policy != fpfa_pkg::POL_BEST) && (r_policy != fpfa_pkg::POL_WORST);
    assign w_issue = (r_state == fpfa_pkg::ST_SCAN) && (r_addr < r_limit)
                   && !(r_found && w_first);

    // result register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_fin_go   = (r_state == fpfa_pkg::ST_FIN) && w_out_free;

    fpfa_store #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_load_wr),
        .i_wr_addr  (IDX_W'(w_in_idx)),
        .i_wr_size  (SIZE_BITS'(w_in_size)),
        .i_set_en   (w_fin_go && (r_cmd == fpfa_pkg::CMD_ALLOC) && r_found),
        .i_set_addr (r_pick),
        .i_rd_addr  (r_addr[IDX_W-1:0]),
        .o_rd_size  (w_rd_size),
        .o_rd_used  (w_rd_used)
    );

    fpfa_fit_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .i_policy (r_policy),
        .i_found  (r_found),
        .i_best   (r_best),
        .i_size   (w_rd_size),
        .i_used   (w_rd_used),
        .i_req    (r_req),
        .o_rest   (w_rest),
        .o_flags  (w_flags)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpfa_pkg::POL_FIRST;
            r_count  <= fpfa_pkg::BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpfa_pkg::REG_FIT_POLICY:  r_policy <= i_cfg_data[1:0];
                fpfa_pkg::REG_BLOCK_COUNT: r_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpfa_pkg::ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = (w_in_cmd == fpfa_pkg::CMD_LOAD) ? fpfa_pkg::ST_FIN
                                                               : fpfa_pkg::ST_SCAN;
                end
            end
            fpfa_pkg::ST_SCAN: begin
                // done once nothing is issued and the last read is judged
                if (!w_issue && !r_ev_valid) begin
                    n_state = fpfa_pkg::ST_FIN;
                end
            end
            fpfa_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = fpfa_pkg::ST_IDLE;
                end
            end
            default: n_state = fpfa_pkg::ST_IDLE;
        endcase
    end

    // datapath and output register next values
    always_comb begin
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_addr       = r_addr;
        n_limit      = r_limit;
        n_ev_valid   = 1'b0;
        n_ev_idx     = r_ev_idx;
        n_found      = r_found;
        n_pick       = r_pick;
        n_best       = r_best;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_block  = r_out_block;
        n_out_left   = r_out_left;

        if (w_s_acc) begin
            n_cmd   = w_in_cmd;
            n_req   = SIZE_BITS'(w_in_size);
            n_addr  = '0;
            n_found = 1'b0;
            // block count above the table size acts as the table size
            n_limit = ({26'd0, r_count} > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(r_count);
        end

        if (r_state == fpfa_pkg::ST_SCAN) begin
            // read issue, memory data returns in the next cycle
            n_ev_valid = w_issue;
            n_ev_idx   = r_addr[IDX_W-1:0];
            if (w_issue) begin
                n_addr = CNT_W'(r_addr + 1'b1);
            end
            if (r_ev_valid && w_flags.take) begin
                n_found = 1'b1;
                n_pick  = r_ev_idx;
                n_best  = w_rest;
            end
        end

        if (w_fin_go) begin
            n_out_valid = 1'b1;
            if (r_cmd == fpfa_pkg::CMD_LOAD) begin
                n_out_status = fpfa_pkg::STAT_LOADED;
                n_out_block  = '0;
                n_out_left   = '0;
            end else if (r_found) begin
                n_out_status = fpfa_pkg::STAT_ALLOC;
                n_out_block  = 5'(r_pick);
                n_out_left   = 16'(r_best);
            end else begin
                n_out_status = fpfa_pkg::STAT_NOFIT;
                n_out_block  = '0;
                n_out_left   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpfa_pkg::ST_IDLE;
            r_ev_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cmd       <= fpfa_pkg::CMD_LOAD;
            r_addr      <= '0;
            r_limit     <= '0;
        end else begin
            r_state     <= n_state;
            r_ev_valid  <= n_ev_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_cmd       <= n_cmd;
            r_addr      <= n_addr;
            r_limit     <= n_limit;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_ev_idx     <= n_ev_idx;
        r_pick       <= n_pick;
        r_best       <= n_best;
        r_out_status <= n_out_status;
        r_out_block  <= n_out_block;
        r_out_left   <= n_out_left;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'd0, r_out_left, r_out_block};

    // a judged entry always lies inside the scan range
    `FPFA_ASSERT_HOLDS(a_ev_in_range, r_ev_valid, r_ev_idx < r_limit)
    // load skips the scan
    `FPFA_ASSERT_NEXT(a_load_to_fin, w_s_acc && (w_in_cmd == fpfa_pkg::CMD_LOAD), r_state == fpfa_pkg::ST_FIN)
    // a hit found by the scan is reported as allocated
    `FPFA_ASSERT_NEXT(a_hit_reported, w_fin_go && r_found && (r_cmd == fpfa_pkg::CMD_ALLOC), m_axis_tuser == fpfa_pkg::STAT_ALLOC)
    // no memory read is left pending when a new beat can enter
    `FPFA_ASSERT_HOLDS(a_idle_no_pending, s_axis_tready, !r_ev_valid)

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the fixed partition fit allocator core
`timescale 1ns / 1ps

// expected result of one request beat
typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  block;
    logic [15:0] leftover;
} t_grant;

class alloc_table_scoreboard;
    logic [15:0] sizes [fpfa_pkg::MAX_BLOCKS_DEF];
    bit          used [fpfa_pkg::MAX_BLOCKS_DEF];
    logic [1:0]  policy;
    logic [5:0]  count;
    t_grant      pending_grants[$];
    int          errors;

    function new();
        foreach (sizes[k]) sizes[k] = '0;
        foreach (used[k]) used[k] = 1'b0;
        policy = fpfa_pkg::POL_FIRST;
        count  = fpfa_pkg::BLOCK_COUNT_RST;
        errors = 0;
    endfunction

    function void configure(logic [fpfa_pkg::CFG_IDX_W-1:0] index,
                            logic [fpfa_pkg::CFG_DATA_W-1:0] data);
        if (index == fpfa_pkg::REG_FIT_POLICY) begin
            policy = data[1:0];
        end else begin
            count = data;
        end
    endfunction

    // walks the table the way the allocator does and updates the copy
    function t_grant predict_grant(logic cmd, logic [4:0] idx, logic [15:0] req);
        t_grant      g;
        int          lim;
        int          pick;
        logic [15:0] best;
        logic [15:0] rest;
        bit          found;
        bit          stop;
        g = '{status: fpfa_pkg::STAT_LOADED, block: '0, leftover: '0};
        if (cmd == fpfa_pkg::CMD_LOAD) begin
            sizes[idx] = req;
            used[idx]  = 1'b0;
            return g;
        end
        lim   = (count > fpfa_pkg::MAX_BLOCKS_DEF) ? fpfa_pkg::MAX_BLOCKS_DEF : int'(count);
        found = 1'b0;
        stop  = 1'b0;
        pick  = 0;
        best  = '0;
        for (int k = 0; k < lim && !stop; k++) begin
            if (!used[k] && sizes[k] >= req) begin
                rest = sizes[k] - req;
                if (!found) begin
                    found = 1'b1;
                    pick  = k;
                    best  = rest;
                    // first fit and the spare code stop at the first hit
                    if (policy != fpfa_pkg::POL_BEST && policy != fpfa_pkg::POL_WORST) begin
                        stop = 1'b1;
                    end
                end else if (policy == fpfa_pkg::POL_BEST && rest < best) begin
                    pick = k;
                    best = rest;
                end else if (policy == fpfa_pkg::POL_WORST && rest > best) begin
                    pick = k;
                    best = rest;
                end
            end
        end
        if (!found) begin
            g.status = fpfa_pkg::STAT_NOFIT;
            return g;
        end
        used[pick]  = 1'b1;
        g.status    = fpfa_pkg::STAT_ALLOC;
        g.block     = pick[4:0];
        g.leftover  = best;
        return g;
    endfunction

    function void note_request(logic cmd, logic [4:0] idx, logic [15:0] req);
        pending_grants.push_back(predict_grant(cmd, idx, req));
    endfunction

    function void check_result(logic [1:0] status, logic [4:0] block, logic [15:0] leftover);
        t_grant g;
        if (pending_grants.size() == 0) begin
            $error("result beat with nothing pending: status %0d block %0d leftover %0d",
                   status, block, leftover);
            errors++;
            return;
        end
        g = pending_grants.pop_front();
        if (status !== g.status) begin
            $error("status: expected %0d, actual %0d", g.status, status);
            errors++;
        end
        if (block !== g.block) begin
            $error("chosen_block: expected %0d, actual %0d", g.block, block);
            errors++;
        end
        if (leftover !== g.leftover) begin
            $error("leftover: expected %0d, actual %0d", g.leftover, leftover);
            errors++;
        end
    endfunction
endclass

module tb_top;

    // spare policy code, behaves as first fit
    localparam logic [1:0] POL_SPARE = 2'd3;
    // cycles without any accepted beat before the run is declared hung;
    // far above an allocate plus the longest stall and sender gap
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASES      = 9;
    localparam int PHASE_BEATS = 44;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [fpfa_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [fpfa_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // block_index[4:0], size_value[20:5], zero pad
    logic [0:0]  s_axis_tuser = '0;     // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // chosen_block[4:0], leftover[20:5], zero pad
    logic [1:0]  m_axis_tuser;          // status[1:0]

    alloc_table_scoreboard table_sb = new();

    // no idling on either side while set
    bit calm = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    fixed_partition_fit_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // request beats are predicted as they are taken, results checked as they leave
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            table_sb.note_request(s_axis_tuser[0], s_axis_tdata[4:0], s_axis_tdata[20:5]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            table_sb.check_result(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[20:5]);
        end
    end

    // hang detection: any beat on either side restarts the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STUCK_LIMIT) begin
            $display("fixed_partition_fit_allocator_core regression: fail");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // present one beat and hold it until the allocator takes it
    task automatic send_beat(logic cmd, logic [4:0] idx, logic [15:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, value, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // random sender gap between beats
    task automatic maybe_pause();
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    // stop sending and wait for every pending result, then let the core go idle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (table_sb.pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [fpfa_pkg::CFG_IDX_W-1:0] index,
                             logic [fpfa_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        table_sb.configure(index, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // policy code in the low bits, junk above that the core must ignore
    task automatic set_policy(logic [1:0] pol);
        logic [3:0] junk;
        junk = $urandom_range(0, 15);
        write_reg(fpfa_pkg::REG_FIT_POLICY, {junk, pol});
    endtask

    // sizes lean small so ties and exact fits are common
    function automatic logic [15:0] pick_size();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 31));
        endcase
    endfunction

    initial begin
        logic [1:0] pol_plan [PHASES];
        logic [5:0] cnt_plan [PHASES];
        int lim;
        logic [4:0] idx;

        pol_plan = '{fpfa_pkg::POL_BEST, fpfa_pkg::POL_WORST, fpfa_pkg::POL_FIRST, POL_SPARE,
                     fpfa_pkg::POL_BEST, fpfa_pkg::POL_WORST, fpfa_pkg::POL_FIRST,
                     fpfa_pkg::POL_BEST, fpfa_pkg::POL_WORST};
        cnt_plan = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd5, 6'd32, 6'd17, 6'd2, 6'd40};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty range, every allocate misses
        write_reg(fpfa_pkg::REG_BLOCK_COUNT, 6'd0);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd0);
        drain();

        // best fit over four blocks: exact fit, tie to the lower index,
        // zero request, full-size request, then a full table
        write_reg(fpfa_pkg::REG_BLOCK_COUNT, 6'd4);
        set_policy(fpfa_pkg::POL_BEST);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd0, 16'd100);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd1, 16'd50);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd2, 16'd100);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd3, 16'hFFFF);
        // loaded past block_count, stays out of the scan
        send_beat(fpfa_pkg::CMD_LOAD, 5'd31, 16'd0);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd50);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd60);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd31, 16'd0);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'hFFFF);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd0);
        drain();

        // worst fit with a tie on the largest leftover, then an oversize request
        set_policy(fpfa_pkg::POL_WORST);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd0, 16'd7);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd1, 16'd9);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd2, 16'd9);
        send_beat(fpfa_pkg::CMD_LOAD, 5'd3, 16'd3);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd2);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd2);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'hFFFF);
        drain();

        // spare code acts as first fit
        set_policy(POL_SPARE);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd0);
        drain();
        set_policy(fpfa_pkg::POL_FIRST);
        send_beat(fpfa_pkg::CMD_ALLOC, 5'd0, 16'd1);
        drain();

        // fill the whole table so no scan can hit a never-loaded entry
        for (int k = 0; k < fpfa_pkg::MAX_BLOCKS_DEF; k++) begin
            send_beat(fpfa_pkg::CMD_LOAD, 5'(k), pick_size());
            maybe_pause();
        end
        drain();

        // random phases, each under its own setting; the drain between
        // phases doubles as the full sender hold-off
        for (int p = 0; p < PHASES; p++) begin
            calm = (p == 2) || (p == PHASES - 1);
            set_policy(pol_plan[p]);
            write_reg(fpfa_pkg::REG_BLOCK_COUNT, cnt_plan[p]);
            lim = (cnt_plan[p] == 0) ? 1 :
                  (cnt_plan[p] > fpfa_pkg::MAX_BLOCKS_DEF) ? fpfa_pkg::MAX_BLOCKS_DEF
                                                           : int'(cnt_plan[p]);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 99) < 40) begin
                    // reloads favor the active range so blocks keep coming back
                    idx = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, lim - 1))
                                                     : 5'($urandom_range(0, 31));
                    send_beat(fpfa_pkg::CMD_LOAD, idx, pick_size());
                end else begin
                    send_beat(fpfa_pkg::CMD_ALLOC, 5'($urandom_range(0, 31)), pick_size());
                end
                maybe_pause();
            end
            drain();
        end

        // tail: nothing pending, give a stray result time to show up
        repeat (40) @(posedge i_clk);
        if (table_sb.errors == 0) begin
            $display("fixed_partition_fit_allocator_core regression: pass");
        end else begin
            $display("fixed_partition_fit_allocator_core regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fpfa_pkg.sv
rtl/fpfa_store.sv
rtl/fpfa_fit_unit.sv
rtl/fixed_partition_fit_allocator_core.sv
sim/tb_top.sv
